/* design/qprp_pkg.sv */
// ----------------------------------------------------------------------------
// qprp_pkg
// Shared widths, register codes and bus types for the quaternion point
// rotate and project pipeline.
// ----------------------------------------------------------------------------
package qprp_pkg;

    // Field widths of the streams and configuration registers.
    localparam int COORD_W    = 16;
    localparam int Q_W        = 16;
    localparam int SCR_W      = 16;

    // Intermediate widths: first product, first Hamilton sum, second product,
    // second Hamilton sum.
    localparam int PROD1_W    = COORD_W + Q_W;
    localparam int P_W        = PROD1_W + 2;
    localparam int PROD2_W    = P_W + Q_W;
    localparam int R_W        = PROD2_W + 2;

    // Screen mapping: rotated values carry 2^-28 scale, the extra halving
    // makes the combined shift 29 bits.
    localparam int FRAC_SHIFT = 29;
    localparam int HP_W       = SCR_W + 1;
    localparam int SUM_W      = R_W + 1;
    localparam int SH_W       = SUM_W - FRAC_SHIFT;

    // Configuration port.
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROT_W = 3'd0,
        REG_ROT_X = 3'd1,
        REG_ROT_Y = 3'd2,
        REG_ROT_Z = 3'd3,
        REG_PAN_X = 3'd4,
        REG_PAN_Y = 3'd5
    } t_reg_idx;

    // Rotation quaternion in Q1.14.
    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_quat;

    // Result of v * conj(q).
    typedef struct packed {
        logic                  pen;
        logic signed [P_W-1:0] p0;
        logic signed [P_W-1:0] p1;
        logic signed [P_W-1:0] p2;
        logic signed [P_W-1:0] p3;
    } t_conj_bus;

    // Rotated x and y, scale 2^-28.
    typedef struct packed {
        logic                  pen;
        logic signed [R_W-1:0] r1;
        logic signed [R_W-1:0] r2;
    } t_rot_bus;

    localparam logic signed [SH_W-1:0] SCR_MAX = SH_W'(2 ** (SCR_W - 1) - 1);
    localparam logic signed [SH_W-1:0] SCR_MIN = -SCR_MAX - SH_W'(1);

    // Clamp a floored screen value to the signed 16-bit range.
    function automatic logic signed [SCR_W-1:0] sat_scr(input logic signed [SH_W-1:0] v);
        logic signed [SCR_W-1:0] res;
        if (v > SCR_MAX) begin
            res = SCR_W'(SCR_MAX);
        end else if (v < SCR_MIN) begin
            res = SCR_W'(SCR_MIN);
        end else begin
            res = SCR_W'(v);
        end
        return res;
    endfunction

endpackage

/* design/qprp_conj_stage.sv */
// ----------------------------------------------------------------------------
// qprp_conj_stage
// Two pipeline stages forming p = (0,v) * conj(q): twelve coordinate by
// component products, then the four Hamilton sums.
// ----------------------------------------------------------------------------
module qprp_conj_stage (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_pen,
    input  logic signed [qprp_pkg::COORD_W-1:0]   i_vx,
    input  logic signed [qprp_pkg::COORD_W-1:0]   i_vy,
    input  logic signed [qprp_pkg::COORD_W-1:0]   i_vz,
    input  qprp_pkg::t_quat                       i_q,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output qprp_pkg::t_conj_bus                   o_bus
);
    import qprp_pkg::*;

    logic                       r_a_valid;
    logic                       r_b_valid;
    logic                       r_a_pen;
    logic signed [PROD1_W-1:0]  r_m [12];
    logic signed [PROD1_W-1:0]  n_m [12];
    t_conj_bus                  r_b;
    t_conj_bus                  n_b;
    logic                       w_a_ready;
    logic                       w_b_ready;

    // Each stage takes a new transaction when it is empty or its data moves on.
    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_bus     = r_b;

    // Products, ordered in groups of three per Hamilton term.
    always_comb begin
        n_m[0]  = PROD1_W'(i_vx) * PROD1_W'(i_q.x);
        n_m[1]  = PROD1_W'(i_vy) * PROD1_W'(i_q.y);
        n_m[2]  = PROD1_W'(i_vz) * PROD1_W'(i_q.z);
        n_m[3]  = PROD1_W'(i_vx) * PROD1_W'(i_q.w);
        n_m[4]  = PROD1_W'(i_vy) * PROD1_W'(i_q.z);
        n_m[5]  = PROD1_W'(i_vz) * PROD1_W'(i_q.y);
        n_m[6]  = PROD1_W'(i_vx) * PROD1_W'(i_q.z);
        n_m[7]  = PROD1_W'(i_vy) * PROD1_W'(i_q.w);
        n_m[8]  = PROD1_W'(i_vz) * PROD1_W'(i_q.x);
        n_m[9]  = PROD1_W'(i_vx) * PROD1_W'(i_q.y);
        n_m[10] = PROD1_W'(i_vy) * PROD1_W'(i_q.x);
        n_m[11] = PROD1_W'(i_vz) * PROD1_W'(i_q.w);
    end

    // Hamilton sums with the conjugate signs folded in.
    always_comb begin
        n_b.pen = r_a_pen;
        n_b.p0  = P_W'(r_m[0]) + P_W'(r_m[1]) + P_W'(r_m[2]);
        n_b.p1  = P_W'(r_m[3]) - P_W'(r_m[4]) + P_W'(r_m[5]);
        n_b.p2  = P_W'(r_m[6]) + P_W'(r_m[7]) - P_W'(r_m[8]);
        n_b.p3  = P_W'(r_m[10]) + P_W'(r_m[11]) - P_W'(r_m[9]);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_pen <= i_pen;
            r_m     <= n_m;
        end
        if (w_b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

endmodule

/* design/qprp_rot_stage.sv */
// ----------------------------------------------------------------------------
// qprp_rot_stage
// Two pipeline stages forming the x and y parts of q * p: eight component
// by partial-sum products, then the two Hamilton sums.
// ----------------------------------------------------------------------------
module qprp_rot_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  qprp_pkg::t_conj_bus  i_bus,
    input  qprp_pkg::t_quat      i_q,
    output logic                 o_valid,
    input  logic                 i_ready,
    output qprp_pkg::t_rot_bus   o_bus
);
    import qprp_pkg::*;

    logic                       r_a_valid;
    logic                       r_b_valid;
    logic                       r_a_pen;
    logic signed [PROD2_W-1:0]  r_m [8];
    logic signed [PROD2_W-1:0]  n_m [8];
    t_rot_bus                   r_b;
    t_rot_bus                   n_b;
    logic                       w_a_ready;
    logic                       w_b_ready;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_bus     = r_b;

    // First four products feed the rotated x, the last four the rotated y.
    always_comb begin
        n_m[0] = PROD2_W'(i_q.w) * PROD2_W'(i_bus.p1);
        n_m[1] = PROD2_W'(i_q.x) * PROD2_W'(i_bus.p0);
        n_m[2] = PROD2_W'(i_q.y) * PROD2_W'(i_bus.p3);
        n_m[3] = PROD2_W'(i_q.z) * PROD2_W'(i_bus.p2);
        n_m[4] = PROD2_W'(i_q.w) * PROD2_W'(i_bus.p2);
        n_m[5] = PROD2_W'(i_q.x) * PROD2_W'(i_bus.p3);
        n_m[6] = PROD2_W'(i_q.y) * PROD2_W'(i_bus.p0);
        n_m[7] = PROD2_W'(i_q.z) * PROD2_W'(i_bus.p1);
    end

    // Hamilton sums for the x and y components.
    always_comb begin
        n_b.pen = r_a_pen;
        n_b.r1  = R_W'(r_m[0]) + R_W'(r_m[1]) + R_W'(r_m[2]) - R_W'(r_m[3]);
        n_b.r2  = R_W'(r_m[4]) - R_W'(r_m[5]) + R_W'(r_m[6]) + R_W'(r_m[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_pen <= i_bus.pen;
            r_m     <= n_m;
        end
        if (w_b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

endmodule

/* design/qprp_screen_stage.sv */
// ----------------------------------------------------------------------------
// qprp_screen_stage
// Output register stage: adds half the screen size and the pan offset,
// floors by the combined shift and saturates to signed 16 bits.
// ----------------------------------------------------------------------------
module qprp_screen_stage #(
    parameter int HALF_X = 512,
    parameter int HALF_Y = 384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  qprp_pkg::t_rot_bus                  i_bus,
    input  logic signed [qprp_pkg::SCR_W-1:0]   i_pan_x,
    input  logic signed [qprp_pkg::SCR_W-1:0]   i_pan_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_pen,
    output logic signed [qprp_pkg::SCR_W-1:0]   o_scr_x,
    output logic signed [qprp_pkg::SCR_W-1:0]   o_scr_y
);
    import qprp_pkg::*;

    logic                      r_valid;
    logic                      r_pen;
    logic signed [SCR_W-1:0]   r_scr_x;
    logic signed [SCR_W-1:0]   r_scr_y;
    logic signed [HP_W-1:0]    w_off_x;
    logic signed [HP_W-1:0]    w_off_y;
    logic signed [SUM_W-1:0]   w_sum_x;
    logic signed [SUM_W-1:0]   w_sum_y;
    logic signed [SH_W-1:0]    w_sh_x;
    logic signed [SH_W-1:0]    w_sh_y;
    logic                      w_ready;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_pen   = r_pen;
    assign o_scr_x = r_scr_x;
    assign o_scr_y = r_scr_y;

    // Screen center plus pan, aligned to the rotated values and added exactly.
    always_comb begin
        w_off_x = HP_W'(HALF_X) + HP_W'(i_pan_x);
        w_off_y = HP_W'(HALF_Y) + HP_W'(i_pan_y);
        w_sum_x = (SUM_W'(w_off_x) <<< FRAC_SHIFT) + SUM_W'(i_bus.r1);
        w_sum_y = (SUM_W'(w_off_y) <<< FRAC_SHIFT) + SUM_W'(i_bus.r2);
        // Dropping the low bits of a two's complement value floors it.
        w_sh_x  = w_sum_x[SUM_W-1:FRAC_SHIFT];
        w_sh_y  = w_sum_y[SUM_W-1:FRAC_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_pen   <= i_bus.pen;
            r_scr_x <= sat_scr(w_sh_x);
            r_scr_y <= sat_scr(w_sh_y);
        end
    end

endmodule

/* design/quaternion_point_rotate_project_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_point_rotate_project_unit
// Rotates 3D vertices by a configured quaternion and maps them to screen
// pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one vertex per transaction, tdata carries pt_x, pt_y, pt_z
//   and tuser carries the pen command (0 move, 1 draw). Output stream: tdata
//   carries screen_x and screen_y, tuser carries the pen command unchanged.
//   The APB port holds rot_w, rot_x, rot_y, rot_z (Q1.14) and pan_x, pan_y
//   at byte addresses 0, 4, ... 20; write it only while the pipeline is empty.
//   Accepted input transactions reach output valid through five register
//   stages: a product stage and a sum stage for v * conj(q), the same pair
//   for q * p, and the output register that offsets, floors and saturates.
//   Throughput is one vertex per cycle while the receiver keeps tready high;
//   each stage holds one transaction and the widest operation in any stage
//   is a 16 by 34 bit multiply.
//   Reset clears all stage valid bits and loads the identity rotation with
//   zero pan. When the receiver stalls, stages fill up behind the output
//   register and tready falls only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module quaternion_point_rotate_project_unit #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Vertex input stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [47:0]                     i_s_tdata,  // pt_x, pt_y, pt_z
    input  logic                            i_s_tuser,  // cmd
    // Screen point output stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,  // screen_x, screen_y
    output logic                            o_m_tuser,  // pen_draw
    // Configuration port.
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [qprp_pkg::APB_AW-1:0]     i_paddr,
    input  logic [qprp_pkg::APB_DW-1:0]     i_pwdata,
    output logic [qprp_pkg::APB_DW-1:0]     o_prdata,
    output logic                            o_pready
);
    import qprp_pkg::*;

    localparam int HALF_X = SCREEN_WIDTH / 2;
    localparam int HALF_Y = SCREEN_HEIGHT / 2;

    t_quat                    r_q;
    logic signed [SCR_W-1:0]  r_pan_x;
    logic signed [SCR_W-1:0]  r_pan_y;
    t_reg_idx                 w_idx;
    logic                     w_wr;

    logic                     w_conj_valid;
    logic                     w_conj_ready;
    t_conj_bus                w_conj_bus;
    logic                     w_rot_valid;
    logic                     w_rot_ready;
    t_rot_bus                 w_rot_bus;
    logic signed [SCR_W-1:0]  w_scr_x;
    logic signed [SCR_W-1:0]  w_scr_y;

    // Register file access.
    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.w   <= Q_W'(16384);
            r_q.x   <= '0;
            r_q.y   <= '0;
            r_q.z   <= '0;
            r_pan_x <= '0;
            r_pan_y <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROT_W: r_q.w   <= i_pwdata[Q_W-1:0];
                REG_ROT_X: r_q.x   <= i_pwdata[Q_W-1:0];
                REG_ROT_Y: r_q.y   <= i_pwdata[Q_W-1:0];
                REG_ROT_Z: r_q.z   <= i_pwdata[Q_W-1:0];
                REG_PAN_X: r_pan_x <= i_pwdata[SCR_W-1:0];
                REG_PAN_Y: r_pan_y <= i_pwdata[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data, zero extended.
    always_comb begin
        unique case (w_idx)
            REG_ROT_W: o_prdata = APB_DW'(r_q.w);
            REG_ROT_X: o_prdata = APB_DW'(r_q.x);
            REG_ROT_Y: o_prdata = APB_DW'(r_q.y);
            REG_ROT_Z: o_prdata = APB_DW'(r_q.z);
            REG_PAN_X: o_prdata = APB_DW'(r_pan_x);
            REG_PAN_Y: o_prdata = APB_DW'(r_pan_y);
            default:   o_prdata = '0;
        endcase
        o_prdata = {{(APB_DW - 16){1'b0}}, o_prdata[15:0]};
    end

    // First Hamilton product.
    qprp_conj_stage u_conj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pen   (i_s_tuser),
        .i_vx    (i_s_tdata[15:0]),
        .i_vy    (i_s_tdata[31:16]),
        .i_vz    (i_s_tdata[47:32]),
        .i_q     (r_q),
        .o_valid (w_conj_valid),
        .i_ready (w_conj_ready),
        .o_bus   (w_conj_bus)
    );

    // Second Hamilton product.
    qprp_rot_stage u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_conj_valid),
        .o_ready (w_conj_ready),
        .i_bus   (w_conj_bus),
        .i_q     (r_q),
        .o_valid (w_rot_valid),
        .i_ready (w_rot_ready),
        .o_bus   (w_rot_bus)
    );

    // Screen mapping and output register.
    qprp_screen_stage #(
        .HALF_X (HALF_X),
        .HALF_Y (HALF_Y)
    ) u_screen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_valid),
        .o_ready (w_rot_ready),
        .i_bus   (w_rot_bus),
        .i_pan_x (r_pan_x),
        .i_pan_y (r_pan_y),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pen   (o_m_tuser),
        .o_scr_x (w_scr_x),
        .o_scr_y (w_scr_y)
    );

    assign o_m_tdata = {w_scr_y, w_scr_x};

endmodule

/* design/qprp_checker.sv */
// ----------------------------------------------------------------------------
// qprp_checker
// Port-level checks for the rotate and project unit, bound to the top level.
// ----------------------------------------------------------------------------
module qprp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [47:0]                     i_s_tdata,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [31:0]                     o_m_tdata,
    input logic                            o_m_tuser,
    input logic                            i_psel,
    input logic                            i_penable,
    input logic                            i_pwrite,
    input logic [qprp_pkg::APB_AW-1:0]     i_paddr,
    input logic [qprp_pkg::APB_DW-1:0]     i_pwdata,
    input logic [qprp_pkg::APB_DW-1:0]     o_prdata,
    input logic                            o_pready
);
    import qprp_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // With nothing waiting at the output, the pipeline has room for input.
    a_accept_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output register is empty");

    // A stalled output transaction holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("output changed while stalled");

    // A write to the rotation scalar reads back on the next cycle.
    a_rot_w_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && o_pready && i_paddr == '0
        |=> !(i_psel && !i_pwrite && i_paddr == '0)
            || o_prdata == {16'd0, $past(i_pwdata[15:0])})
        else $error("rot_w readback mismatch");

endmodule

bind quaternion_point_rotate_project_unit qprp_checker u_qprp_checker (.*);
